/* sv/cpa_pkg.sv */
// ---------------------------------------------------------------------------
// cpa_pkg: shared constants for the packet airtime calculator
// Widths, register indexes, reset values and reciprocal tables.
// ---------------------------------------------------------------------------
package cpa_pkg;

  // field and datapath widths
  localparam int unsigned SF_W   = 4;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned AIR_W  = 22;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned Y_W    = 29;   // (time_units + 999) >> 3
  localparam int unsigned Q0_W   = 23;   // reciprocal quotient estimate
  localparam int unsigned REM_W  = 30;
  localparam int unsigned RCP_W  = 15;   // 2^16 / d reciprocal width

  // largest airtime the datapath can produce
  localparam logic [AIR_W-1:0] AIR_MAX = AIR_W'(2200000);

  // spreading factor limits
  localparam logic [SF_W-1:0] SF_MIN = 4'd6;
  localparam logic [SF_W-1:0] SF_MAX = 4'd12;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_BW_SEL   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_CODE_RT  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_PREAMBLE = 3'd2;
  localparam logic [IDX_W-1:0] CFG_IMPLICIT = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CRC_EN   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_LOW_RATE = 3'd5;

  // register reset values
  localparam logic [1:0]       BW_RST  = 2'd0;
  localparam logic [2:0]       CR_RST  = 3'd1;
  localparam logic [CFG_W-1:0] PRE_RST = 16'd8;

  // floor(2^32 / 125): estimate is the true quotient or one below it
  localparam logic [25:0] RECIP125 = 26'd34359738;
  localparam logic [7:0]  DIV_125  = 8'd125;

  // ceil(2^16 / d) for symbol divisors 4..12, exact for dividends below 1024
  function automatic logic [RCP_W-1:0] sym_recip(input logic [SF_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      4'd4:    r = 15'd16384;
      4'd5:    r = 15'd13108;
      4'd6:    r = 15'd10923;
      4'd7:    r = 15'd9363;
      4'd8:    r = 15'd8192;
      4'd9:    r = 15'd7282;
      4'd10:   r = 15'd6554;
      4'd11:   r = 15'd5958;
      4'd12:   r = 15'd5462;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/cpa_ms_div.sv */
// ---------------------------------------------------------------------------
// cpa_ms_div: two-stage divide by 125 with valid/ready
// Reciprocal multiply gives an estimate, a remainder check corrects it.
// ---------------------------------------------------------------------------
module cpa_ms_div
  import cpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Y_W-1:0]   dividend_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [AIR_W-1:0] quotient_o
);

  logic             va_q, vb_q;
  logic             en_a, en_b;
  logic [54:0]      prod;
  logic [Q0_W-1:0]  q0_q;
  logic [Y_W-1:0]   ya_q;
  logic [REM_W-1:0] m125;
  logic [REM_W-1:0] rem;
  logic [AIR_W-1:0] quo_d, quo_q;

  // stage enables: a stage loads when it is empty or drains this cycle
  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  // estimate quotient by reciprocal multiply
  assign prod = 55'(dividend_i) * 55'(RECIP125);

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      q0_q <= prod[54:32];
      ya_q <= dividend_i;
    end
  end

  // correct the estimate: remainder of at least 125 means one more
  assign m125  = {q0_q, 7'b0} - {6'b0, q0_q, 1'b0} - {7'b0, q0_q};
  assign rem   = {1'b0, ya_q} - m125;
  assign quo_d = q0_q[AIR_W-1:0] + ((rem >= REM_W'(DIV_125)) ? AIR_W'(1) : AIR_W'(0));

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      quo_q <= quo_d;
    end
  end

  assign valid_o    = vb_q;
  assign quotient_o = quo_q;

  // estimate is never more than one below the true quotient
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> rem < REM_W'(250))
    else $error("divide estimate off by more than one");

  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> va_q)
    else $error("accepted word lost in divider");

  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> quotient_o <= AIR_MAX)
    else $error("airtime beyond largest reachable value");

endmodule

/* sv/chirp_packet_airtime.sv */
// ---------------------------------------------------------------------------
// chirp_packet_airtime: packet time on air in milliseconds
// Six-stage pipeline from spreading factor and payload length to airtime.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o   | spreading_factor_i, payload_length_i
//  out      | out_valid_o / out_ready_i | airtime_ms_o
//  cfg      | cfg_we_i (no wait)        | cfg_index_i, cfg_wdata_i
//
//  One word enters per cycle while in_ready_o is high; six register stages (symbol
//  count, reciprocal divide, symbol total, scale, divide-by-125 estimate,
//  correction with output register) carry each word to the output.
//  Reset clears all stage valid bits and loads the register defaults.
//  A stalled output holds only the stages behind it that are full; empty
//  stages keep filling, so input is taken while a result waits until every
//  stage is full.
// ---------------------------------------------------------------------------
module chirp_packet_airtime
  import cpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SF_W-1:0]  spreading_factor_i,
  input  logic [LEN_W-1:0] payload_length_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AIR_W-1:0] airtime_ms_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [1:0]       bw_q;
  logic [2:0]       cr_q;
  logic [CFG_W-1:0] pre_q;
  logic             impl_q, crc_q, lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= BW_RST;
      cr_q   <= CR_RST;
      pre_q  <= PRE_RST;
      impl_q <= 1'b0;
      crc_q  <= 1'b1;
      lr_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BW_SEL:   bw_q   <= cfg_wdata_i[1:0];
        CFG_CODE_RT:  cr_q   <= cfg_wdata_i[2:0];
        CFG_PREAMBLE: pre_q  <= cfg_wdata_i;
        CFG_IMPLICIT: impl_q <= cfg_wdata_i[0];
        CFG_CRC_EN:   crc_q  <= cfg_wdata_i[0];
        CFG_LOW_RATE: lr_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic div_ready;

  assign en4        = !v4_q || div_ready;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: saturate, form ceil(num/4) and bias for the ceiling divide
  logic [SF_W-1:0] sf_sat;
  logic [SF_W-1:0] d1_d;
  logic [11:0]     pos, neg, diff, diff3;
  logic [9:0]      mcnt, x1_d;
  logic [SF_W-1:0] sf1_q, d1_q;
  logic [9:0]      x1_q;

  always_comb begin
    if (spreading_factor_i < SF_MIN) begin
      sf_sat = SF_MIN;
    end else if (spreading_factor_i > SF_MAX) begin
      sf_sat = SF_MAX;
    end else begin
      sf_sat = spreading_factor_i;
    end
  end

  assign d1_d  = sf_sat - {2'b00, lr_q, 1'b0};
  assign pos   = {1'b0, payload_length_i, 3'b000} + 12'd28 + (crc_q ? 12'd16 : 12'd0);
  assign neg   = {6'b0, sf_sat, 2'b00} + (impl_q ? 12'd20 : 12'd0);
  assign diff  = pos - neg;
  assign diff3 = diff + 12'd3;
  assign mcnt  = (pos > neg) ? diff3[11:2] : 10'd0;
  assign x1_d  = mcnt + {6'b0, d1_d} - 10'd1;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      sf1_q <= sf_sat;
      d1_q  <= d1_d;
      x1_q  <= x1_d;
    end
  end

  // stage 2: divide by the symbol divisor through its reciprocal
  logic [24:0]     prod2;
  logic [7:0]      q2_q;
  logic [9:0]      x2_q;
  logic [SF_W-1:0] sf2_q, d2_q;

  assign prod2 = 25'(x1_q) * 25'(sym_recip(d1_q));

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      q2_q  <= prod2[23:16];
      x2_q  <= x1_q;
      d2_q  <= d1_q;
      sf2_q <= sf1_q;
    end
  end

  // stage 3: coded symbols, preamble and quarter-symbol total
  logic [2:0]      cr_sat;
  logic [3:0]      cr_mul;
  logic [11:0]     psym;
  logic [16:0]     tot;
  logic [18:0]     qs3_d, qs3_q;
  logic [SF_W-1:0] sf3_q;

  always_comb begin
    if (cr_q < 3'd1) begin
      cr_sat = 3'd1;
    end else if (cr_q > 3'd4) begin
      cr_sat = 3'd4;
    end else begin
      cr_sat = cr_q;
    end
  end

  assign cr_mul = {1'b0, cr_sat} + 4'd4;
  assign psym   = 12'(q2_q) * 12'(cr_mul) + 12'd8;
  assign tot    = {1'b0, pre_q} + {5'b0, psym};
  assign qs3_d  = {tot, 2'b00} + 19'd17;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      qs3_q <= qs3_d;
      sf3_q <= sf2_q;
    end
  end

  // stage 4: scale to ms*125 units and round up before the divide
  logic [1:0]     bw_sat;
  logic [3:0]     shamt;
  logic [31:0]    scaled, biased;
  logic [Y_W-1:0] y4_q;

  assign bw_sat = (bw_q > 2'd2) ? 2'd2 : bw_q;
  assign shamt  = sf3_q + 4'd1 - {2'b00, bw_sat};
  assign scaled = {13'b0, qs3_q} << shamt;
  assign biased = scaled + 32'd999;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      y4_q <= biased[31:3];
    end
  end

  // stages 5 and 6: divide by 125
  cpa_ms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v4_q),
    .ready_o    (div_ready),
    .dividend_i (y4_q),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .quotient_o (airtime_ms_o)
  );

  // quotient check for the symbol divide
  logic [11:0] qd_chk;
  assign qd_chk = 12'(q2_q) * 12'(d2_q);

  a_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word not captured in first stage");

  a_sym_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (qd_chk <= {2'b00, x2_q}) && ({2'b00, x2_q} < qd_chk + {8'b0, d2_q}))
    else $error("symbol divide quotient wrong");

  a_quarter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (qs3_q[1:0] == 2'b01) && (qs3_q >= 19'd49))
    else $error("quarter-symbol total malformed");

endmodule

/* tb/sv/tb_chirp_packet_airtime.sv */
// ---------------------------------------------------------------------------
// tb_chirp_packet_airtime: self-checking bench for the airtime calculator
// Drives spreading factor / payload length words through the valid-ready
// input. It predicts each packet's time on air from the current register
// settings and checks every output word in order. Random stalls are applied
// on both channels, and the registers are rewritten between drained phases.
// ---------------------------------------------------------------------------
module tb_chirp_packet_airtime;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 8;        // pipeline depth plus margin
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS  = 250;

  // coding rate saturation bounds and bandwidth codes
  localparam logic [2:0] CR_LOW   = 3'd1;
  localparam logic [2:0] CR_HIGH  = 3'd4;
  localparam logic [1:0] BW_250K  = 2'd1;
  localparam logic [1:0] BW_500K  = 2'd2;
  localparam logic [1:0] BW_RSVD  = 2'd3;

  // indexes past the register map; writes there must be dropped
  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SF_W-1:0]  sf;
    logic [LEN_W-1:0] len;
  } airtime_req_t;

  // DUT signals, known from time zero
  logic             clk_i              = 1'b0;
  logic             rst_ni             = 1'b0;
  logic             in_valid_i         = 1'b0;
  logic             in_ready_o;
  logic [SF_W-1:0]  spreading_factor_i = '0;
  logic [LEN_W-1:0] payload_length_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i        = 1'b0;
  logic [AIR_W-1:0] airtime_ms_o;
  logic             cfg_we_i           = 1'b0;
  logic [IDX_W-1:0] cfg_index_i        = '0;
  logic [CFG_W-1:0] cfg_wdata_i        = '0;

  // shadow copy of the register file
  logic [1:0]       bw_sel_q    = BW_RST;
  logic [2:0]       code_rate_q = CR_RST;
  logic [CFG_W-1:0] preamble_q  = PRE_RST;
  logic             implicit_q  = 1'b0;
  logic             crc_en_q    = 1'b1;
  logic             low_rate_q  = 1'b0;

  airtime_req_t     req_q[$];
  logic [AIR_W-1:0] airtime_exp_q[$];
  airtime_req_t     next_req;
  logic [AIR_W-1:0] airtime_exp;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned src_gap       = 0;
  int unsigned snk_gap       = 0;
  int unsigned items_queued  = 0;
  int unsigned words_sent    = 0;
  int unsigned words_seen    = 0;
  int unsigned fail_count    = 0;
  int unsigned settings_seen = 0;
  int unsigned cycle_count   = 0;

  chirp_packet_airtime i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .spreading_factor_i (spreading_factor_i),
    .payload_length_i   (payload_length_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .airtime_ms_o       (airtime_ms_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predict time on air in ms from the shadow registers.
  function automatic logic [AIR_W-1:0] airtime_ms_for(input logic [SF_W-1:0]  sf_in,
                                                      input logic [LEN_W-1:0] len_in);
    longint          sf;
    longint          cr;
    longint          num;
    longint          den;
    longint          sym;
    logic [1:0]      bw;
    longint unsigned quarters;
    longint unsigned bw_div;
    longint unsigned scaled;
    sf = longint'(sf_in);
    if (sf < longint'(SF_MIN)) sf = longint'(SF_MIN);
    if (sf > longint'(SF_MAX)) sf = longint'(SF_MAX);
    cr = longint'(code_rate_q);
    if (cr < longint'(CR_LOW))  cr = longint'(CR_LOW);
    if (cr > longint'(CR_HIGH)) cr = longint'(CR_HIGH);
    bw = (bw_sel_q == BW_RSVD) ? BW_500K : bw_sel_q;
    // coded data symbols, ceiling divide, none when the numerator is not positive
    num = 8 * longint'(len_in) - 4 * sf + 28 + 16 * longint'(crc_en_q)
          - 20 * longint'(implicit_q);
    den = 4 * (sf - 2 * longint'(low_rate_q));
    sym = 8;
    if (num > 0) sym += ((num + den - 1) / den) * (cr + 4);
    // quarter symbols scaled by 2^sf, then round up past .001 ms
    quarters = 4 * (longint'(preamble_q) + sym) + 17;
    bw_div   = 64'd500 << bw;
    scaled   = 1000 * (quarters << sf) + 999 * bw_div;
    return AIR_W'(scaled / (1000 * bw_div));
  endfunction

  // Update the shadow registers; unmapped indexes change nothing.
  function automatic void shadow_write(input logic [IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    case (idx)
      CFG_BW_SEL:   bw_sel_q    = val[1:0];
      CFG_CODE_RT:  code_rate_q = val[2:0];
      CFG_PREAMBLE: preamble_q  = val;
      CFG_IMPLICIT: implicit_q  = val[0];
      CFG_CRC_EN:   crc_en_q    = val[0];
      CFG_LOW_RATE: low_rate_q  = val[0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic write_all(input logic [1:0] bw, input logic [2:0] cr,
                           input logic [CFG_W-1:0] pre, input logic impl,
                           input logic crc, input logic low);
    write_reg(CFG_BW_SEL,   CFG_W'(bw));
    write_reg(CFG_CODE_RT,  CFG_W'(cr));
    write_reg(CFG_PREAMBLE, pre);
    write_reg(CFG_IMPLICIT, CFG_W'(impl));
    write_reg(CFG_CRC_EN,   CFG_W'(crc));
    write_reg(CFG_LOW_RATE, CFG_W'(low));
    settings_seen++;
  endtask

  task automatic queue_req(input logic [SF_W-1:0] sf, input logic [LEN_W-1:0] len);
    req_q.push_back('{sf: sf, len: len});
    items_queued++;
  endtask

  // Hold until every queued word has produced its result, then let the pipe settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (words_seen < items_queued);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver: record accepted words, then load the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        airtime_exp_q.push_back(airtime_ms_for(spreading_factor_i, payload_length_i));
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0 && $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(8, 1) - 1;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          next_req = req_q.pop_front();
          in_valid_i         <= 1'b1;
          spreading_factor_i <= next_req.sf;
          payload_length_i   <= next_req.len;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest prediction, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (airtime_exp_q.size() == 0) begin
          $display("%0t: airtime_ms expected none, actual %0d", $time, airtime_ms_o);
          fail_count++;
        end else begin
          airtime_exp = airtime_exp_q.pop_front();
          if (airtime_ms_o !== airtime_exp) begin
            $display("%0t: airtime_ms expected %0d, actual %0d",
                     $time, airtime_exp, airtime_ms_o);
            fail_count++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(99) < snk_stall_pct) begin
        snk_gap = $urandom_range(8, 1) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d words sent, %0d results seen",
               $time, words_sent, words_seen);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed corners, then random phases under fresh settings.
  initial begin : stimulus
    logic [CFG_W-1:0] pre;
    logic [LEN_W-1:0] len;
    int unsigned      sel;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 30;
    snk_stall_pct = 30;

    // reset settings: field extremes and out-of-range spreading factors
    settings_seen++;
    queue_req(4'd0, 8'd0);
    queue_req(4'd15, 8'd255);
    queue_req(4'd6, 8'd0);
    queue_req(4'd12, 8'd255);
    queue_req(4'd5, 8'd17);
    queue_req(4'd13, 8'd200);
    queue_req(4'd7, 8'd1);
    queue_req(4'd11, 8'd128);
    wait_drained();

    // reserved bandwidth, coding rate above range, longest preamble, all flags flipped
    write_all(BW_RSVD, 3'd7, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    queue_req(4'd12, 8'd0);     // numerator below zero
    queue_req(4'd15, 8'd255);
    queue_req(4'd0, 8'd255);
    queue_req(4'd6, 8'd3);
    queue_req(4'd12, 8'd255);
    wait_drained();

    // coding rate zero, empty preamble; writes past the map must be dropped
    write_all(BW_250K, 3'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h5A5A);
    queue_req(4'd12, 8'd0);
    queue_req(4'd12, 8'd2);
    queue_req(4'd6, 8'd0);
    queue_req(4'd9, 8'd77);
    queue_req(4'd15, 8'd0);
    wait_drained();

    // widest bandwidth, slowest coding rate
    write_all(BW_500K, CR_HIGH, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    queue_req(4'd6, 8'd255);
    queue_req(4'd12, 8'd255);
    queue_req(4'd0, 8'd0);
    wait_drained();

    // random phases; the last one runs without any idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = $urandom_range(3);
      case (sel)
        0: pre = '0;
        1: pre = 16'hFFFF;
        2: pre = CFG_W'($urandom_range(64));
        default: pre = CFG_W'($urandom_range(16'hFFFF));
      endcase
      write_all(2'($urandom_range(3)), 3'($urandom_range(7)), pre,
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (ph == RANDOM_PHASES - 1) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end else begin
        src_idle_pct  = (ph % 3 == 0) ? 0 : $urandom_range(50, 10);
        snk_stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(50, 10);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // short payloads often, to reach the empty payload term
        len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(6)) : LEN_W'($urandom_range(255));
        queue_req(SF_W'($urandom_range(15)), len);
        // pause the sender mid phase until the pipe is empty
        if (n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    $display("Sent %0d requests, checked %0d airtime results", words_sent, words_seen);
    $display("Register settings exercised: %0d, mismatches: %0d", settings_seen, fail_count);
    if (fail_count == 0 && airtime_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
